### sv/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef logic [2:0] kind_t;
    typedef logic [1:0] rank_t;

    localparam kind_t KIND_OPERAND = 3'd0;
    localparam kind_t KIND_LPAREN  = 3'd1;
    localparam kind_t KIND_RPAREN  = 3'd2;
    localparam kind_t KIND_OPER    = 3'd3;
    localparam kind_t KIND_FLUSH   = 3'd4;

    // lowest rank stands for "no priority", below every real operator
    localparam rank_t RANK_NONE = 2'd0;
    localparam rank_t RANK_ADD  = 2'd1;
    localparam rank_t RANK_MUL  = 2'd2;
    localparam rank_t RANK_POW  = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] sym;
        rank_t      rank;
    } cmd_t;

    function automatic rank_t rank_of(input logic [7:0] c);
        rank_t r;
        case (c)
            CH_PLUS, CH_MINUS: r = RANK_ADD;
            CH_STAR, CH_SLASH: r = RANK_MUL;
            CH_CARET:          r = RANK_POW;
            default:           r = RANK_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]};
    endfunction

endpackage

### sv/itp_in_if.sv
`timescale 1ns / 1ps

interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       flush;

    modport source (output valid, symbol, flush, input ready);
    modport sink   (input valid, symbol, flush, output ready);
endinterface

### sv/itp_out_if.sv
`timescale 1ns / 1ps

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       end_of_expr;
    logic       last_of_run;
    logic       overflow;

    modport source (output valid, out_symbol, end_of_expr, last_of_run, overflow, input ready);
    modport sink   (input valid, out_symbol, end_of_expr, last_of_run, overflow, output ready);
endinterface

### sv/itp_front.sv
`timescale 1ns / 1ps

module itp_front (
    itp_in_if.sink       symbols,
    output itp_pkg::cmd_t cmd,
    output logic         cmd_valid,
    input  logic         cmd_ready
);
    import itp_pkg::*;

    kind_t kind;

    always_comb
    begin
        if (symbols.flush)
        begin
            kind = KIND_FLUSH;
        end
        else if (is_operand(symbols.symbol))
        begin
            kind = KIND_OPERAND;
        end
        else if (symbols.symbol == CH_LPAREN)
        begin
            kind = KIND_LPAREN;
        end
        else if (symbols.symbol == CH_RPAREN)
        begin
            kind = KIND_RPAREN;
        end
        else
        begin
            kind = KIND_OPER;
        end
    end

    assign cmd.kind      = kind;
    assign cmd.sym       = symbols.symbol;
    assign cmd.rank      = rank_of(symbols.symbol);
    assign cmd_valid     = symbols.valid;
    assign symbols.ready = cmd_ready;

endmodule

### sv/itp_queue.sv
`timescale 1ns / 1ps

module itp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  itp_pkg::cmd_t wr_data,
    input  logic          wr_valid,
    output logic          wr_ready,
    output itp_pkg::cmd_t rd_data,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import itp_pkg::*;

    cmd_t       data_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = data_reg[rd_ptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/itp_back.sv
`timescale 1ns / 1ps

module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  itp_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    itp_out_if.source     postfix
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]    mem [STACK_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [7:0]    push_sym_reg;
    logic          top_push_reg;
    logic          top_push_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic          pend_valid_reg;
    logic          pend_valid_next;
    logic          pend_final_reg;
    logic [7:0]    pend_sym_reg;
    logic          pend_end_reg;
    logic          pend_ovf_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_sym_reg;
    logic          out_end_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;

    logic [7:0]    top;
    logic          nonempty;
    logic          full;
    logic          out_free;
    logic          step_go;
    logic          move;
    logic          move_last;
    logic [CW-1:0] below_top;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    logic          emit;
    logic          done;
    logic          do_pop;
    logic          do_push;
    logic [7:0]    e_sym;
    logic          e_end;
    logic          e_ovf;
    logic          pop_en;
    logic          push_en;

    assign top       = top_push_reg ? push_sym_reg : rd_data_reg;
    assign nonempty  = count_reg != '0;
    assign full      = count_reg == CW'(STACK_DEPTH);
    assign out_free  = !out_valid_reg || postfix.ready;
    assign step_go   = cmd_valid && (!pend_valid_reg || out_free);
    assign below_top = count_reg - CW'(2);
    assign rd_addr   = below_top[AW-1:0];
    assign wr_addr   = count_reg[AW-1:0];

    always_comb
    begin
        emit    = 1'b0;
        done    = 1'b0;
        do_pop  = 1'b0;
        do_push = 1'b0;
        e_sym   = CH_NUL;
        e_end   = 1'b0;
        e_ovf   = 1'b0;
        case (cmd.kind)
            KIND_FLUSH:
            begin
                emit = 1'b1;
                if (nonempty)
                begin
                    e_sym  = top;
                    do_pop = 1'b1;
                end
                else
                begin
                    e_end = 1'b1;
                    done  = 1'b1;
                end
            end
            KIND_OPERAND:
            begin
                emit  = 1'b1;
                e_sym = cmd.sym;
                done  = 1'b1;
            end
            KIND_LPAREN:
            begin
                done = 1'b1;
                if (full)
                begin
                    emit  = 1'b1;
                    e_ovf = 1'b1;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            KIND_RPAREN:
            begin
                if (nonempty && top != CH_LPAREN)
                begin
                    emit   = 1'b1;
                    e_sym  = top;
                    do_pop = 1'b1;
                end
                else
                begin
                    do_pop = nonempty;
                    done   = 1'b1;
                end
            end
            KIND_OPER:
            begin
                if (nonempty && cmd.rank <= rank_of(top))
                begin
                    emit   = 1'b1;
                    e_sym  = top;
                    do_pop = 1'b1;
                end
                else if (full)
                begin
                    emit  = 1'b1;
                    e_ovf = 1'b1;
                    done  = 1'b1;
                end
                else
                begin
                    do_push = 1'b1;
                    done    = 1'b1;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    assign pop_en    = step_go && do_pop;
    assign push_en   = step_go && do_push;
    assign cmd_ready = step_go && done;

    // a held result goes out once the next step shows whether more follow
    assign move      = pend_valid_reg && out_free && (pend_final_reg || step_go);
    assign move_last = pend_final_reg || !emit;

    always_comb
    begin
        count_next    = count_reg;
        top_push_next = top_push_reg;
        if (push_en)
        begin
            count_next    = count_reg + CW'(1);
            top_push_next = 1'b1;
        end
        else if (pop_en)
        begin
            count_next    = count_reg - CW'(1);
            top_push_next = 1'b0;
        end

        pend_valid_next = pend_valid_reg;
        if (step_go && emit)
        begin
            pend_valid_next = 1'b1;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (postfix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[wr_addr] <= cmd.sym;
            push_sym_reg <= cmd.sym;
        end
        if (pop_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (step_go && emit)
        begin
            pend_final_reg <= done;
            pend_sym_reg   <= e_sym;
            pend_end_reg   <= e_end;
            pend_ovf_reg   <= e_ovf;
        end
        if (move)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_end_reg  <= pend_end_reg;
            out_ovf_reg  <= pend_ovf_reg;
            out_last_reg <= move_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            top_push_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            top_push_reg   <= top_push_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign postfix.valid       = out_valid_reg;
    assign postfix.out_symbol  = out_sym_reg;
    assign postfix.end_of_expr = out_end_reg;
    assign postfix.last_of_run = out_last_reg;
    assign postfix.overflow    = out_ovf_reg;

endmodule

### sv/infix_to_postfix_converter.sv
`timescale 1ns / 1ps

// infix to postfix conversion with an operator stack of STACK_DEPTH entries
// symbols: one character (or a flush) per transfer, valid/ready
// postfix: result characters per transfer, valid/ready; last_of_run marks the
//   final result of one input, end_of_expr the end marker after a flush,
//   overflow a push dropped on a full stack
// an input that causes no result (a push, a ')' that only drops its '(')
//   delivers nothing on postfix
// the front classifies and writes a two-entry queue; the back runs one stack
//   step per cycle while postfix is not stalled: a step emits one character, pushes, or pops
// an input passes the queue, then its results the pending and the output register
// stack steps are emitted operators, pushes, dropped '(', overflow flags and end
//   markers; a stream of operands flows at one per cycle while postfix is ready;
//   a pop does not hold up the next step since the stack memory read of the next
//   top is issued in the pop cycle
// when postfix stalls, the back holds one finished and one pending result,
//   then stops, and the queue fills before symbols drops ready
// reset clears the stack count, the queue and both result stages; stack
//   entries are not cleared and are never used as the top before written
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    itp_in_if.sink    symbols,
    itp_out_if.source postfix
);
    import itp_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    itp_front u_front (
        .symbols   (symbols),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    itp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (back_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .postfix   (postfix)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (postfix.valid && postfix.end_of_expr) |->
        (postfix.last_of_run && !postfix.overflow && postfix.out_symbol == CH_NUL))
        else $error("end marker malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (postfix.valid && postfix.overflow) |->
        (postfix.last_of_run && !postfix.end_of_expr && postfix.out_symbol == CH_NUL))
        else $error("overflow flag malformed");

    assert property (@(posedge clk) !rst_n |=> !postfix.valid)
        else $error("result valid after reset");
`endif

endmodule
